[src/seven_point_stencil_matvec_unit_macros.svh]
// Assertion macros used by the stencil product top level
`ifndef SEVEN_POINT_STENCIL_MATVEC_UNIT_MACROS_SVH
`define SEVEN_POINT_STENCIL_MATVEC_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define STC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stencil assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stencil assertion failed");

`endif

[src/stencil_pkg.sv]
// Types, constants and tap tables of the seven-point stencil product unit
package stencil_pkg;

    localparam int MAX_PLANE  = 4096;
    localparam int MAX_POINTS = 16777216;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 13;
    localparam int CNT_W  = 25;
    localparam int ACC_W  = 2 * DATA_W + 4;

    // History window: a power of two at least four planes deep, so that
    // entries still in use are never overwritten by items in flight
    localparam int HIST_DEPTH = 4 * MAX_PLANE;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int NUM_CELLS  = 7;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [ACC_W-1:0] ROUND_ADD =
        (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;

    // Configuration register indexes
    localparam logic [1:0] REG_ROW   = 2'd0;
    localparam logic [1:0] REG_PLANE = 2'd1;
    localparam logic [1:0] REG_TOTAL = 2'd2;

    // Offsets of a tap relative to the point being computed
    localparam logic [2:0] OFS_ZERO = 3'd0;
    localparam logic [2:0] OFS_P1   = 3'd1;
    localparam logic [2:0] OFS_PR   = 3'd2;
    localparam logic [2:0] OFS_PP   = 3'd3;
    localparam logic [2:0] OFS_M1   = 3'd4;
    localparam logic [2:0] OFS_MR   = 3'd5;
    localparam logic [2:0] OFS_MP   = 3'd6;

    // Coefficient field stored by a cell
    localparam logic [1:0] COEF_DIAG = 2'd0;
    localparam logic [1:0] COEF_X    = 2'd1;
    localparam logic [1:0] COEF_Y    = 2'd2;
    localparam logic [1:0] COEF_Z    = 2'd3;

    typedef struct packed {
        logic [2:0] coef_sel;
        logic [2:0] vec_sel;
    } t_tap;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CNT_W-1:0]  m;
        logic [CNT_W-1:0]  lim;
        logic [LEN_W-1:0]  row;
        logic [LEN_W-1:0]  plane;
    } t_ctx;

    typedef struct packed {
        logic                     en;
        logic [HIST_AW-1:0]       addr;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] vec;
    } t_wr;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     overflow;
        logic                     last;
    } t_res;

    // Tap of each cell along the chain
    function automatic t_tap cell_tap(input int k);
        t_tap t;
        case (k)
            0:       t = '{coef_sel: OFS_ZERO, vec_sel: OFS_ZERO};
            1:       t = '{coef_sel: OFS_ZERO, vec_sel: OFS_P1};
            2:       t = '{coef_sel: OFS_ZERO, vec_sel: OFS_PR};
            3:       t = '{coef_sel: OFS_ZERO, vec_sel: OFS_PP};
            4:       t = '{coef_sel: OFS_M1,   vec_sel: OFS_M1};
            5:       t = '{coef_sel: OFS_MR,   vec_sel: OFS_MR};
            6:       t = '{coef_sel: OFS_MP,   vec_sel: OFS_MP};
            default: t = '{coef_sel: OFS_ZERO, vec_sel: OFS_ZERO};
        endcase
        return t;
    endfunction

    // Coefficient field of each cell along the chain
    function automatic logic [1:0] cell_coef(input int k);
        logic [1:0] c;
        case (k)
            1, 4:    c = COEF_X;
            2, 5:    c = COEF_Y;
            3, 6:    c = COEF_Z;
            default: c = COEF_DIAG;
        endcase
        return c;
    endfunction

endpackage

[src/stencil_in_if.sv]
// Channel carrying grid point and drain transactions
interface stencil_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     action;
    logic signed [stencil_pkg::DATA_W-1:0]    diag_coef;
    logic signed [stencil_pkg::DATA_W-1:0]    x_coef;
    logic signed [stencil_pkg::DATA_W-1:0]    y_coef;
    logic signed [stencil_pkg::DATA_W-1:0]    z_coef;
    logic signed [stencil_pkg::DATA_W-1:0]    vec_value;

    modport source (output valid, action, diag_coef, x_coef, y_coef, z_coef, vec_value,
                    input ready);
    modport sink   (input valid, action, diag_coef, x_coef, y_coef, z_coef, vec_value,
                    output ready);
endinterface

[src/stencil_out_if.sv]
// Channel carrying product result transactions
interface stencil_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [stencil_pkg::DATA_W-1:0]    product_value;
    logic                                     overflow;
    logic                                     last_point;

    modport source (output valid, product_value, overflow, last_point, input ready);
    modport sink   (input valid, product_value, overflow, last_point, output ready);
endinterface

[src/stencil_ram.sv]
// Generic simple dual-port RAM with registered read
module stencil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/stencil_cell.sv]
// One stencil tap: local history copy, product and partial sum hand-off
module stencil_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  stencil_pkg::t_tap                     i_tap,
    input  stencil_pkg::t_wr                      i_wr,
    input  stencil_pkg::t_ctx                     i_ctx,
    input  logic signed [stencil_pkg::ACC_W-1:0]  i_acc,
    output stencil_pkg::t_ctx                     o_ctx,
    output logic signed [stencil_pkg::ACC_W-1:0]  o_acc
);
    localparam int IDX_W = stencil_pkg::CNT_W + 2;
    localparam int OFS_W = stencil_pkg::LEN_W + 2;

    // Signed offset of a tap code
    function automatic logic signed [OFS_W-1:0] tap_ofs(
        input logic [2:0]                     code,
        input logic [stencil_pkg::LEN_W-1:0]  row,
        input logic [stencil_pkg::LEN_W-1:0]  plane
    );
        logic signed [OFS_W-1:0] o;
        case (code)
            stencil_pkg::OFS_P1: o = OFS_W'(1);
            stencil_pkg::OFS_PR: o = $signed({2'b00, row});
            stencil_pkg::OFS_PP: o = $signed({2'b00, plane});
            stencil_pkg::OFS_M1: o = -OFS_W'(1);
            stencil_pkg::OFS_MR: o = -$signed({2'b00, row});
            stencil_pkg::OFS_MP: o = -$signed({2'b00, plane});
            default:             o = '0;
        endcase
        return o;
    endfunction

    logic signed [IDX_W-1:0]                coef_idx;
    logic signed [IDX_W-1:0]                vec_idx;
    logic                                   vec_ok;
    logic                                   negate;
    logic signed [stencil_pkg::DATA_W-1:0]  coef_rd;
    logic signed [stencil_pkg::DATA_W-1:0]  vec_rd;
    logic signed [stencil_pkg::ACC_W-1:0]   term_ext;
    logic signed [stencil_pkg::ACC_W-1:0]   term;

    stencil_pkg::t_ctx                      r_ctx1, r_ctx2, r_ctx3;
    logic                                   r_ok1, r_ok2;
    logic signed [stencil_pkg::ACC_W-1:0]   r_acc_d1, r_acc_d2, r_acc;
    logic signed [2*stencil_pkg::DATA_W-1:0] r_prod;

    // Address the taps and check the neighbor against the received range
    assign coef_idx = $signed({2'b00, i_ctx.m})
                    + IDX_W'(tap_ofs(i_tap.coef_sel, i_ctx.row, i_ctx.plane));
    assign vec_idx  = $signed({2'b00, i_ctx.m})
                    + IDX_W'(tap_ofs(i_tap.vec_sel, i_ctx.row, i_ctx.plane));
    assign vec_ok   = (i_tap.vec_sel == stencil_pkg::OFS_ZERO)
                    || (!vec_idx[IDX_W-1]
                        && (vec_idx[IDX_W-2:0] < {1'b0, i_ctx.lim}));

    // Diagonal term adds, every coupling term subtracts
    assign negate = (i_tap.vec_sel != stencil_pkg::OFS_ZERO)
                 || (i_tap.coef_sel != stencil_pkg::OFS_ZERO);

    stencil_ram #(.WIDTH(stencil_pkg::DATA_W), .DEPTH(stencil_pkg::HIST_DEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.coef),
        .i_raddr (coef_idx[stencil_pkg::HIST_AW-1:0]),
        .o_rdata (coef_rd)
    );

    stencil_ram #(.WIDTH(stencil_pkg::DATA_W), .DEPTH(stencil_pkg::HIST_DEPTH)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.vec),
        .i_raddr (vec_idx[stencil_pkg::HIST_AW-1:0]),
        .o_rdata (vec_rd)
    );

    assign term_ext = stencil_pkg::ACC_W'(r_prod);
    assign term     = !r_ok2 ? '0 : (negate ? -term_ext : term_ext);

    // Advance context and partial sum through read, multiply and add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx1 <= '0;
            r_ctx2 <= '0;
            r_ctx3 <= '0;
        end else begin
            r_ctx1 <= i_ctx;
            r_ctx2 <= r_ctx1;
            r_ctx3 <= r_ctx2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1    <= vec_ok;
        r_acc_d1 <= i_acc;
        r_ok2    <= r_ok1;
        r_acc_d2 <= r_acc_d1;
        r_prod   <= coef_rd * vec_rd;
        r_acc    <= r_acc_d2 + term;
    end

    assign o_ctx = r_ctx3;
    assign o_acc = r_acc;
endmodule

[src/stencil_fifo.sv]
// Result queue feeding the output channel
module stencil_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stencil_pkg::t_res  i_data,
    output logic               o_pop,
    stencil_out_if.source      o_res
);
    stencil_pkg::t_res                r_mem [stencil_pkg::FIFO_DEPTH];
    logic [stencil_pkg::FIFO_AW-1:0]  r_wr, r_rd;
    logic [stencil_pkg::FIFO_AW:0]    r_count;
    stencil_pkg::t_res                head;

    assign head                = r_mem[r_rd];
    assign o_res.valid         = (r_count != '0);
    assign o_res.product_value = head.value;
    assign o_res.overflow      = head.overflow;
    assign o_res.last_point    = head.last;
    assign o_pop               = o_res.valid && o_res.ready;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (stencil_pkg::FIFO_AW+1)'(i_push)
                               - (stencil_pkg::FIFO_AW+1)'(o_pop);
        end
    end
endmodule

[src/seven_point_stencil_matvec_unit.sv]
// Top level of the seven-point stencil matrix-vector product unit
//
//   channel   dir   handshake        payload
//   i_pt      in    valid / ready    action, diag/x/y/z coef, vec_value
//   o_res     out   valid / ready    product_value, overflow, last_point
//   i_cfg_*   in    write enable     index, data (row, plane, total)
//
// One transaction is taken per cycle while ready is high. A result passes
// one context stage, the chain of seven tap cells (three stages per cell) and
// one rounding stage, then waits in a 32-entry queue. Ready drops while 32
// results are in flight or queued, and while the end-of-grid hold counts down
// after a grid's last point is launched, until every cell has read its history.
// Reset clears counters, queue and chain; history RAMs are left uncleared.
`include "seven_point_stencil_matvec_unit_macros.svh"
module seven_point_stencil_matvec_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [stencil_pkg::CNT_W-1:0]   i_cfg_data,
    stencil_in_if.sink                      i_pt,
    stencil_out_if.source                   o_res
);
    localparam int CW = stencil_pkg::CNT_W;
    localparam int LW = stencil_pkg::LEN_W;
    localparam int AW = stencil_pkg::ACC_W;
    localparam int DW = stencil_pkg::DATA_W;
    localparam int NC = stencil_pkg::NUM_CELLS;
    localparam int QW = stencil_pkg::FIFO_AW + 1;
    localparam int HOLD = 3 * (NC - 1);
    localparam int HW   = $clog2(HOLD + 1);

    logic [LW-1:0] r_row_len, r_plane_len;
    logic [CW-1:0] r_total;
    logic [LW-1:0] eff_row, eff_plane;
    logic [CW-1:0] eff_total;

    logic [CW-1:0] r_received, r_emitted, n_received, n_emitted;
    logic [CW-1:0] recv_after;
    logic [QW-1:0] r_credit;
    logic [HW-1:0] r_hold;
    logic          accept, emit, write, last, pop;

    stencil_pkg::t_ctx             r_ctx;
    stencil_pkg::t_ctx             ctx_chain [NC+1];
    logic signed [AW-1:0]          acc_chain [NC+1];
    stencil_pkg::t_wr              wr_port   [NC];

    logic signed [AW-1:0]          sum;
    logic signed [AW-1:0]          shifted;
    logic [AW-DW:0]                hi_bits;
    logic                          r_fin_valid;
    stencil_pkg::t_res             r_fin;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len   <= LW'(64);
            r_plane_len <= LW'(4096);
            r_total     <= CW'(262144);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stencil_pkg::REG_ROW:   r_row_len   <= i_cfg_data[LW-1:0];
                stencil_pkg::REG_PLANE: r_plane_len <= i_cfg_data[LW-1:0];
                stencil_pkg::REG_TOTAL: r_total     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the registers to their working ranges
    assign eff_row   = (r_row_len == '0) ? LW'(1)
                     : ((r_row_len > LW'(stencil_pkg::MAX_PLANE))
                        ? LW'(stencil_pkg::MAX_PLANE) : r_row_len);
    assign eff_plane = (r_plane_len == '0) ? LW'(1)
                     : ((r_plane_len > LW'(stencil_pkg::MAX_PLANE))
                        ? LW'(stencil_pkg::MAX_PLANE) : r_plane_len);
    assign eff_total = (r_total == '0) ? CW'(1)
                     : ((r_total > CW'(stencil_pkg::MAX_POINTS))
                        ? CW'(stencil_pkg::MAX_POINTS) : r_total);

    assign i_pt.ready = (r_credit < QW'(stencil_pkg::FIFO_DEPTH)) && (r_hold == '0);
    assign accept     = i_pt.valid && i_pt.ready;
    assign last       = (r_emitted == eff_total - 1'b1);

    // Decide store and emit for the accepted transaction
    always_comb begin
        n_received = r_received;
        n_emitted  = r_emitted;
        recv_after = r_received;
        emit       = 1'b0;
        write      = 1'b0;
        if (accept) begin
            if (i_pt.action) begin
                if (r_emitted < r_received) begin
                    emit = 1'b1;
                end else if (r_received >= eff_total) begin
                    n_received = '0;
                    n_emitted  = '0;
                end
            end else if (r_received < eff_total) begin
                write      = 1'b1;
                n_received = r_received + 1'b1;
                recv_after = n_received;
                if (({1'b0, r_emitted} + (CW+1)'(eff_plane)) < {1'b0, n_received}) begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                n_emitted = r_emitted + 1'b1;
                if (last) begin
                    n_received = '0;
                    n_emitted  = '0;
                end
            end
        end
    end

    // Advance counters, result credit and the end-of-grid hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_received <= '0;
            r_emitted  <= '0;
            r_credit   <= '0;
            r_hold     <= '0;
        end else begin
            r_received <= n_received;
            r_emitted  <= n_emitted;
            r_credit   <= r_credit + QW'(emit) - QW'(pop);
            if (emit && last) begin
                r_hold <= HW'(HOLD);
            end else if (r_hold != '0) begin
                r_hold <= r_hold - 1'b1;
            end
        end
    end

    // Launch the context of an emitted point into the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
        end else begin
            r_ctx.valid <= emit;
            r_ctx.last  <= last;
            r_ctx.m     <= r_emitted;
            r_ctx.lim   <= (recv_after < eff_total) ? recv_after : eff_total;
            r_ctx.row   <= eff_row;
            r_ctx.plane <= eff_plane;
        end
    end

    assign ctx_chain[0] = r_ctx;
    assign acc_chain[0] = '0;

    // Chain of tap cells, each with its own history copy
    for (genvar k = 0; k < NC; k++) begin : g_cell
        always_comb begin
            wr_port[k].en   = write;
            wr_port[k].addr = r_received[stencil_pkg::HIST_AW-1:0];
            wr_port[k].vec  = i_pt.vec_value;
            case (stencil_pkg::cell_coef(k))
                stencil_pkg::COEF_X: wr_port[k].coef = i_pt.x_coef;
                stencil_pkg::COEF_Y: wr_port[k].coef = i_pt.y_coef;
                stencil_pkg::COEF_Z: wr_port[k].coef = i_pt.z_coef;
                default:             wr_port[k].coef = i_pt.diag_coef;
            endcase
        end

        stencil_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tap   (stencil_pkg::cell_tap(k)),
            .i_wr    (wr_port[k]),
            .i_ctx   (ctx_chain[k]),
            .i_acc   (acc_chain[k]),
            .o_ctx   (ctx_chain[k+1]),
            .o_acc   (acc_chain[k+1])
        );
    end

    // Round to nearest, ties up, then saturate
    assign sum     = acc_chain[NC] + $signed(stencil_pkg::ROUND_ADD);
    assign shifted = sum >>> stencil_pkg::FRAC_BITS;
    assign hi_bits = shifted[AW-1:DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= ctx_chain[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin.last <= ctx_chain[NC].last;
        if ((&hi_bits) || !(|hi_bits)) begin
            r_fin.value    <= shifted[DW-1:0];
            r_fin.overflow <= 1'b0;
        end else begin
            r_fin.value    <= shifted[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            r_fin.overflow <= 1'b1;
        end
    end

    stencil_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_fin_valid),
        .i_data  (r_fin),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    `STC_ASSERT_NOW(a_credit_bound, i_clk, i_rst_n, 1'b1, r_credit <= QW'(stencil_pkg::FIFO_DEPTH))
    `STC_ASSERT_NOW(a_out_has_credit, i_clk, i_rst_n, o_res.valid, r_credit != '0)
    `STC_ASSERT_NEXT(a_emit_behind, i_clk, i_rst_n, 1'b1, r_emitted <= r_received)
endmodule
